[hdl/multichannel_shift_averager_macros.svh]
// Assertion macros shared by the averager RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef MULTICHANNEL_SHIFT_AVERAGER_MACROS_SVH
`define MULTICHANNEL_SHIFT_AVERAGER_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every clock edge outside reset
`define MSA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define MSA_ASSERT_NEXT(name, clk, rst_n, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`else

`define MSA_ASSERT(name, clk, rst_n, prop, msg)
`define MSA_ASSERT_NEXT(name, clk, rst_n, cond, conseq, msg)

`endif

`endif

[hdl/msa_pkg.sv]
package msa_pkg;

    // array geometry and arithmetic widths
    localparam int NUM_BANKS       = 4;
    localparam int NUM_CHANS       = 16;
    localparam int COEFF_FRAC_BITS = 8;
    localparam int SAMPLE_WIDTH    = 16;

    localparam int CELLS      = NUM_BANKS * NUM_CHANS;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int BANK_W     = 2;
    localparam int CHAN_W     = 4;
    localparam int SUM_W      = 32;
    localparam int COEFF_W    = 16;
    localparam int AVG_BITS_W = 4;
    localparam int ACT_BANK_W = 3;
    localparam int ACT_CHAN_W = 5;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = SUM_W + COEFF_W;

    // result buffer
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // saturation limits of the sample range, at product width
    localparam logic signed [PROD_W-1:0] SAT_HI =
        PROD_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_INIT   = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF     = 2'd0,
        CFG_AVG_BITS  = 2'd1,
        CFG_ACT_BANKS = 2'd2,
        CFG_ACT_CHANS = 2'd3
    } t_cfg_idx;

    // one accepted input word
    typedef struct packed {
        t_op                            op;
        logic [BANK_W-1:0]              bank;
        logic [CHAN_W-1:0]              chan;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_item;

    // updated sum, already shifted down by avg_bits
    typedef struct packed {
        logic                    vld;
        logic [BANK_W-1:0]       bank;
        logic [CHAN_W-1:0]       chan;
        logic signed [SUM_W-1:0] mean;
    } t_mean_word;

    // one result word
    typedef struct packed {
        logic                           sat;
        logic signed [SAMPLE_WIDTH-1:0] average;
        logic [CHAN_W-1:0]              chan;
        logic [BANK_W-1:0]              bank;
    } t_result;

endpackage

[hdl/multichannel_shift_averager.sv]
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: bank, channel, sample; tuser: opcode
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: bank, channel, average; tuser: saturated
// cfg       in   i_cfg_we (no wait)              i_cfg_idx, i_cfg_data
//
// One input word per cycle while s_axis_tready is high. A result passes through memory
// read on the accepting edge, then sum update and write-back, gain multiply, and
// clip into the result buffer.
// Back-to-back words for the same cell are covered by forwarding the written sum.
// Reset clears the per-cell valid bits; unwritten cells read as zero.
// s_axis_tready drops once 8 results are owed and not yet taken on m_axis.
module multichannel_shift_averager import msa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [1:0] bank, [5:2] channel, [21:6] sample
    input  logic [0:0]            s_axis_tuser,   // [0] opcode
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [1:0] bank, [5:2] channel, [21:6] average
    output logic [0:0]            m_axis_tuser,   // [0] saturated
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [COEFF_W-1:0] r_coeff;
    logic [AVG_BITS_W-1:0]     r_avg_bits;
    logic [ACT_BANK_W-1:0]     r_act_banks;
    logic [ACT_CHAN_W-1:0]     r_act_chans;

    t_item                     in_item;
    logic                      in_acc;
    logic                      active;
    logic [ACT_BANK_W-1:0]     nb_eff;
    logic [ACT_CHAN_W-1:0]     nc_eff;
    t_mean_word                mean;
    logic                      push;
    t_result                   res;
    t_result                   head;
    logic                      room;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff     <= '0;
            r_avg_bits  <= '0;
            r_act_banks <= ACT_BANK_W'(NUM_BANKS);
            r_act_chans <= ACT_CHAN_W'(NUM_CHANS);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COEFF:     r_coeff     <= $signed(i_cfg_data[COEFF_W-1:0]);
                CFG_AVG_BITS:  r_avg_bits  <= i_cfg_data[AVG_BITS_W-1:0];
                CFG_ACT_BANKS: r_act_banks <= i_cfg_data[ACT_BANK_W-1:0];
                CFG_ACT_CHANS: r_act_chans <= i_cfg_data[ACT_CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input word
    assign in_item.bank   = s_axis_tdata[1:0];
    assign in_item.chan   = s_axis_tdata[5:2];
    assign in_item.sample = $signed(s_axis_tdata[21:6]);
    assign in_item.op     = t_op'(s_axis_tuser[0]);

    // active cell check, counts clamped to the array size
    always_comb begin
        nb_eff = (r_act_banks > ACT_BANK_W'(NUM_BANKS)) ? ACT_BANK_W'(NUM_BANKS)
                                                        : r_act_banks;
        nc_eff = (r_act_chans > ACT_CHAN_W'(NUM_CHANS)) ? ACT_CHAN_W'(NUM_CHANS)
                                                        : r_act_chans;
        active = (ACT_BANK_W'(in_item.bank) < nb_eff)
              && (ACT_CHAN_W'(in_item.chan) < nc_eff);
    end

    assign s_axis_tready = room;
    assign in_acc        = s_axis_tvalid && room;

    msa_sum_unit u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (in_acc && active),
        .i_item     (in_item),
        .i_avg_bits (r_avg_bits),
        .o_mean     (mean)
    );

    msa_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mean  (mean),
        .i_coeff (r_coeff),
        .o_push  (push),
        .o_res   (res)
    );

    msa_out_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (in_acc && active && (in_item.op == OP_UPDATE)),
        .i_push    (push),
        .i_res     (res),
        .i_pop     (m_axis_tready),
        .o_room    (room),
        .o_vld     (m_axis_tvalid),
        .o_res     (head)
    );

    // pack the result word
    assign m_axis_tdata = {2'b00, head.average, head.chan, head.bank};
    assign m_axis_tuser = head.sat;

endmodule

[hdl/msa_sum_unit.sv]
`include "multichannel_shift_averager_macros.svh"

// Running sum memory with read-modify-write.
// The read is issued when a word is accepted; stage 1 then updates the sum and writes it back.
module msa_sum_unit import msa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  t_item                 i_item,
    input  logic [AVG_BITS_W-1:0] i_avg_bits,
    output t_mean_word            o_mean
);

    logic [SUM_W-1:0]        r_mem [CELLS];
    logic [CELLS-1:0]        r_written;

    logic                    r_s1_vld;
    t_item                   r_s1_item;
    logic [IDX_W-1:0]        r_s1_idx;
    logic [SUM_W-1:0]        r_rd_data;
    logic                    r_rd_vld;
    logic                    r_fwd_hit;
    logic signed [SUM_W-1:0] r_fwd_data;
    logic                    r_mean_vld;
    logic [BANK_W-1:0]       r_mean_bank;
    logic [CHAN_W-1:0]       r_mean_chan;
    logic signed [SUM_W-1:0] r_mean_sum;

    logic [IDX_W-1:0]        idx_in;
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] n_sum;

    // cell address of the incoming word
    assign idx_in = IDX_W'(i_item.bank) * IDX_W'(NUM_CHANS) + IDX_W'(i_item.chan);

    // old sum: forwarded write, stored value, or zero for a cell never written
    always_comb begin
        if (r_fwd_hit) begin
            old_sum = r_fwd_data;
        end else if (r_rd_vld) begin
            old_sum = $signed(r_rd_data);
        end else begin
            old_sum = '0;
        end
        x_ext = {{(SUM_W - SAMPLE_WIDTH){r_s1_item.sample[SAMPLE_WIDTH-1]}},
                 r_s1_item.sample};
        if (r_s1_item.op == OP_INIT) begin
            n_sum = x_ext <<< i_avg_bits;
        end else begin
            n_sum = old_sum - (old_sum >>> i_avg_bits) + x_ext;
        end
    end

    // memory: write back in stage 1, read for the new word
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_mem[r_s1_idx] <= n_sum;
        end
        if (i_vld) begin
            r_rd_data <= r_mem[idx_in];
        end
    end

    // payload of the stages
    always_ff @(posedge i_clk) begin
        r_s1_item   <= i_item;
        r_s1_idx    <= idx_in;
        r_fwd_data  <= n_sum;
        r_mean_bank <= r_s1_item.bank;
        r_mean_chan <= r_s1_item.chan;
        r_mean_sum  <= n_sum >>> i_avg_bits;
    end

    // control: valid bits, forwarding, stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_written  <= '0;
            r_fwd_hit  <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_mean_vld <= 1'b0;
        end else begin
            r_s1_vld   <= i_vld;
            r_fwd_hit  <= r_s1_vld && (r_s1_idx == idx_in);
            r_rd_vld   <= r_written[idx_in];
            r_mean_vld <= r_s1_vld && (r_s1_item.op == OP_UPDATE);
            if (r_s1_vld) begin
                r_written[r_s1_idx] <= 1'b1;
            end
        end
    end

    assign o_mean.vld  = r_mean_vld;
    assign o_mean.bank = r_mean_bank;
    assign o_mean.chan = r_mean_chan;
    assign o_mean.mean = r_mean_sum;

    `MSA_ASSERT(a_fwd_has_src, i_clk, i_rst_n, !r_fwd_hit || $past(r_s1_vld),
        "forwarded sum without a write in the previous cycle")
    `MSA_ASSERT_NEXT(a_written_set, i_clk, i_rst_n, r_s1_vld,
        r_written[$past(r_s1_idx)], "written cell not marked valid")
    `MSA_ASSERT(a_mean_has_src, i_clk, i_rst_n, !r_mean_vld || $past(r_s1_vld),
        "mean word without an update in stage 1")

endmodule

[hdl/msa_scale.sv]
// Output gain: multiply stage, then shift and clip to the sample range.
module msa_scale import msa_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mean_word                i_mean,
    input  logic signed [COEFF_W-1:0] i_coeff,
    output logic                      o_push,
    output t_result                   o_res
);

    logic                     r_p_vld;
    logic [BANK_W-1:0]        r_p_bank;
    logic [CHAN_W-1:0]        r_p_chan;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0] scaled;

    // product register
    always_ff @(posedge i_clk) begin
        r_p_bank <= i_mean.bank;
        r_p_chan <= i_mean.chan;
        r_prod   <= i_mean.mean * i_coeff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_mean.vld;
        end
    end

    // fraction drop and saturation
    always_comb begin
        scaled     = r_prod >>> COEFF_FRAC_BITS;
        o_res.bank = r_p_bank;
        o_res.chan = r_p_chan;
        if (scaled > SAT_HI) begin
            o_res.average = SAT_HI[SAMPLE_WIDTH-1:0];
            o_res.sat     = 1'b1;
        end else if (scaled < SAT_LO) begin
            o_res.average = SAT_LO[SAMPLE_WIDTH-1:0];
            o_res.sat     = 1'b1;
        end else begin
            o_res.average = scaled[SAMPLE_WIDTH-1:0];
            o_res.sat     = 1'b0;
        end
    end

    assign o_push = r_p_vld;

endmodule

[hdl/msa_out_fifo.sv]
`include "multichannel_shift_averager_macros.svh"

// Result buffer with credit: a slot is reserved when a producing word is
// accepted, so words already in the pipeline always find room.
module msa_out_fifo import msa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_reserve,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_vld,
    output t_result o_res
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_CW-1:0]   r_owed;

    logic                 pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    // pointers, fill count, outstanding results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_owed   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(i_push) - FIFO_CW'(pop_ok);
            r_owed  <= r_owed + FIFO_CW'(i_reserve) - FIFO_CW'(pop_ok);
        end
    end

    assign o_room = (r_owed < FIFO_CW'(FIFO_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_res  = r_mem[r_rd_ptr];

    `MSA_ASSERT(a_count_le_owed, i_clk, i_rst_n, r_count <= r_owed,
        "more words buffered than reserved")
    `MSA_ASSERT(a_owed_bound, i_clk, i_rst_n, r_owed <= FIFO_CW'(FIFO_DEPTH),
        "reservations exceed buffer depth")
    `MSA_ASSERT(a_push_room, i_clk, i_rst_n,
        !i_push || (r_count < FIFO_CW'(FIFO_DEPTH)) || pop_ok,
        "push into a full buffer")

endmodule
